// ===== sv/p2b_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2b_pkg: shared types and constants of the P2-plus-bubble triangle unit
// Fixed-point widths, node codes and the beat types that travel between the
// front end, the coefficient queue and the node back end.
// ----------------------------------------------------------------------------
package p2b_pkg;

    // Fixed-point format of the coordinates and results
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 20;
    localparam int OUT_W     = 24;
    localparam int NODE_W    = 3;

    // Barycentric weights and shared multiplier operands
    localparam int LW    = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 2;
    localparam int MW    = LW + 1;
    // l1*l2, bubble derivatives, partial products of the triple product
    localparam int P12_W = 2 * IN_W;
    localparam int DW    = IN_W + LW + 1;
    localparam int LO_W  = LW + IN_W + 1;
    localparam int HI_W  = LW + IN_W;
    localparam int PFW   = LW + 2 * IN_W + 1;
    localparam int PHW   = PFW - FRAC_BITS;
    // Node sums with 2*FRAC_BITS fraction bits, and the rounded sum
    localparam int SW_A  = (DW > PHW) ? DW : PHW;
    localparam int SW_B  = (2 * MW > MW + FRAC_BITS) ? 2 * MW : MW + FRAC_BITS;
    localparam int SW    = ((SW_A > SW_B) ? SW_A : SW_B) + 7;
    localparam int RW    = SW - FRAC_BITS;

    // Coefficient queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Constant one in weight format
    localparam logic signed [LW-1:0] ONE_L = {{(LW-1){1'b0}}, 1'b1} << FRAC_BITS;

    // Node numbers: corners, edge midpoints, bubble
    localparam logic [NODE_W-1:0] NODE_V0  = 3'd0;
    localparam logic [NODE_W-1:0] NODE_V1  = 3'd1;
    localparam logic [NODE_W-1:0] NODE_V2  = 3'd2;
    localparam logic [NODE_W-1:0] NODE_E01 = 3'd3;
    localparam logic [NODE_W-1:0] NODE_E12 = 3'd4;
    localparam logic [NODE_W-1:0] NODE_E20 = 3'd5;
    localparam logic [NODE_W-1:0] NODE_BUB = 3'd6;

    // Input beat: one point
    typedef struct packed {
        logic signed [IN_W-1:0] ksi;
        logic signed [IN_W-1:0] eta;
    } item_t;

    // Output beat: one node
    typedef struct packed {
        logic [NODE_W-1:0]       node;
        logic signed [OUT_W-1:0] value;
        logic signed [OUT_W-1:0] grad_ksi;
        logic signed [OUT_W-1:0] grad_eta;
        logic                    last;
    } result_t;

    // Per-point terms handed from front to back
    typedef struct packed {
        logic signed [LW-1:0]  l0;
        logic signed [LW-1:0]  l1;
        logic signed [LW-1:0]  l2;
        logic signed [PHW-1:0] phi;
        logic signed [DW-1:0]  dpk;
        logic signed [DW-1:0]  dpe;
    } coef_t;

endpackage
`default_nettype wire

// ===== sv/p2b_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2b_front: point intake and shared-term sequencer
// Accepts a point, forms the barycentric weights and runs one shared
// multiplier over five steps for l1*l2, the bubble derivatives and the
// rounded bubble term, then pushes the terms into the queue.
// ----------------------------------------------------------------------------
module p2b_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  p2b_pkg::item_t item,
    output logic           push,
    output p2b_pkg::coef_t push_data,
    input  logic           full
);
    import p2b_pkg::*;

    localparam logic [2:0] STEP_P12  = 3'd0;
    localparam logic [2:0] STEP_DPK  = 3'd1;
    localparam logic [2:0] STEP_DPE  = 3'd2;
    localparam logic [2:0] STEP_LO   = 3'd3;
    localparam logic [2:0] STEP_HI   = 3'd4;
    localparam logic [2:0] STEP_PUSH = 3'd5;

    localparam logic signed [PFW-1:0] HALF_F = {{(PFW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic                    act_reg, act_next;
    logic [2:0]              step_reg, step_next;
    logic signed [LW-1:0]    l0_reg, l1_reg, l2_reg;
    logic signed [MW-1:0]    d01_reg, d02_reg;
    logic signed [P12_W-1:0] p12_reg;
    logic signed [DW-1:0]    dpk_reg, dpe_reg;
    logic signed [PFW-1:0]   acc_reg;
    logic signed [HI_W-1:0]  hi_reg;
    logic signed [MW-1:0]    mul_a, mul_b;
    logic signed [2*MW-1:0]  mul_p;
    logic signed [LW-1:0]    l0_in, l1_in, l2_in;
    logic signed [PFW-1:0]   phi_full, phi_shift;
    logic                    accept, done;

    // Handshake: free again in the cycle the terms leave
    assign done   = act_reg && (step_reg == STEP_PUSH) && !full;
    assign busy   = act_reg && !done;
    assign accept = start && !busy;

    // Weights of the incoming point
    assign l1_in = LW'(item.ksi);
    assign l2_in = LW'(item.eta);
    assign l0_in = ONE_L - l1_in - l2_in;

    // Select operands of the shared multiplier
    always_comb
    begin
        unique case (step_reg)
            STEP_P12:
            begin
                mul_a = MW'(l1_reg);
                mul_b = MW'(l2_reg);
            end
            STEP_DPK:
            begin
                mul_a = MW'(l2_reg);
                mul_b = d01_reg;
            end
            STEP_DPE:
            begin
                mul_a = MW'(l1_reg);
                mul_b = d02_reg;
            end
            STEP_LO:
            begin
                mul_a = MW'(l0_reg);
                mul_b = $signed({{(MW-IN_W){1'b0}}, p12_reg[IN_W-1:0]});
            end
            STEP_HI:
            begin
                mul_a = MW'(l0_reg);
                mul_b = MW'($signed(p12_reg[P12_W-1:IN_W]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = (2*MW)'(mul_a) * (2*MW)'(mul_b);

    // Combine the partial products and round the bubble term
    assign phi_full  = (PFW'(hi_reg) <<< IN_W) + acc_reg;
    assign phi_shift = phi_full >>> FRAC_BITS;

    // Advance the step counter
    always_comb
    begin
        act_next  = act_reg;
        step_next = step_reg;
        if (act_reg && (step_reg != STEP_PUSH))
        begin
            step_next = step_reg + 3'd1;
        end
        if (done)
        begin
            act_next = 1'b0;
        end
        if (accept)
        begin
            act_next  = 1'b1;
            step_next = STEP_P12;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            step_reg <= STEP_P12;
        end
        else
        begin
            act_reg  <= act_next;
            step_reg <= step_next;
        end
    end

    // Hold the weights and the products of each step
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            l0_reg <= l0_in;
            l1_reg <= l1_in;
            l2_reg <= l2_in;
        end
        if (act_reg)
        begin
            unique case (step_reg)
                STEP_P12:
                begin
                    p12_reg <= mul_p[P12_W-1:0];
                    d01_reg <= MW'(l0_reg) - MW'(l1_reg);
                    d02_reg <= MW'(l0_reg) - MW'(l2_reg);
                end
                STEP_DPK: dpk_reg <= mul_p[DW-1:0];
                STEP_DPE: dpe_reg <= mul_p[DW-1:0];
                STEP_LO:  acc_reg <= PFW'($signed(mul_p[LO_W-1:0])) + HALF_F;
                STEP_HI:  hi_reg  <= mul_p[HI_W-1:0];
                default:  ;
            endcase
        end
    end

    // Drive the queue beat
    assign push          = done;
    assign push_data.l0  = l0_reg;
    assign push_data.l1  = l1_reg;
    assign push_data.l2  = l2_reg;
    assign push_data.phi = phi_shift[PHW-1:0];
    assign push_data.dpk = dpk_reg;
    assign push_data.dpe = dpe_reg;

endmodule
`default_nettype wire

// ===== sv/p2b_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2b_queue: coefficient queue between front and back
// Small register queue of per-point terms; the head is read in place and
// dropped when the back end has issued the last node of that point.
// ----------------------------------------------------------------------------
module p2b_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  p2b_pkg::coef_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output p2b_pkg::coef_t head
);
    import p2b_pkg::*;

    coef_t             ent_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == Q_CW'(Q_DEPTH));
    assign avail   = (cnt_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && avail;
    assign head    = ent_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/p2b_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2b_back: per-node evaluation pipeline
// Walks nodes 0..6 of the queue head, one per cycle while avail is high,
// via multiply, sum and round-and-saturate stages into the result register.
// ----------------------------------------------------------------------------
module p2b_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             avail,
    input  p2b_pkg::coef_t   head,
    output logic             pop,
    output logic             result_valid,
    output p2b_pkg::result_t result
);
    import p2b_pkg::*;

    localparam logic signed [SW-1:0] HALF_S  = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [RW-1:0] OUT_MAX = RW'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [RW-1:0] OUT_MIN = -RW'(2 ** (OUT_W - 1));

    // Scale by the node's bubble coefficient: 3, -12 or 27
    function automatic logic signed [SW-1:0] coef_mul(input logic signed [SW-1:0] x,
                                                      input logic [NODE_W-1:0] n);
        logic signed [SW-1:0] r;
        unique case (n)
            NODE_V0, NODE_V1, NODE_V2:
                r = (x <<< 1) + x;
            NODE_E01, NODE_E12, NODE_E20:
                r = -((x <<< 3) + (x <<< 2));
            NODE_BUB:
                r = (x <<< 4) + (x <<< 3) + (x <<< 1) + x;
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // Round half up to FRAC_BITS fraction bits and clamp to the output range
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] t;
        logic signed [RW-1:0] r;
        logic signed [RW-1:0] c;
        t = x + HALF_S;
        r = RW'(t >>> FRAC_BITS);
        if (r > OUT_MAX)
        begin
            c = OUT_MAX;
        end
        else if (r < OUT_MIN)
        begin
            c = OUT_MIN;
        end
        else
        begin
            c = r;
        end
        return c[OUT_W-1:0];
    endfunction

    logic [NODE_W-1:0]      cnt_reg, cnt_next;
    logic signed [SW-1:0]   l0s, l1s, l2s, ones, phis, dpks, dpes;
    logic signed [SW-1:0]   lin_k, lin_e;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;
    logic signed [SW-1:0]   qs, qscaled;

    logic                   vld_a_reg, vld_b_reg;
    logic [NODE_W-1:0]      node_a_reg, node_b_reg;
    logic signed [2*MW-1:0] q_a_reg;
    logic signed [SW-1:0]   vadd_a_reg, gk_a_reg, ge_a_reg;
    logic signed [SW-1:0]   v_b_reg, gk_b_reg, ge_b_reg;
    logic                   result_valid_reg;
    result_t                result_reg;

    // Walk the nodes of the head point, drop it after the bubble node
    assign pop = avail && (cnt_reg == NODE_BUB);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (avail)
        begin
            cnt_next = (cnt_reg == NODE_BUB) ? NODE_V0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= NODE_V0;
            vld_a_reg        <= 1'b0;
            vld_b_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg          <= cnt_next;
            vld_a_reg        <= avail;
            vld_b_reg        <= vld_a_reg;
            result_valid_reg <= vld_b_reg;
        end
    end

    // Widen the head terms
    assign l0s  = SW'(head.l0);
    assign l1s  = SW'(head.l1);
    assign l2s  = SW'(head.l2);
    assign ones = SW'(ONE_L);
    assign phis = SW'(head.phi);
    assign dpks = SW'(head.dpk);
    assign dpes = SW'(head.dpe);

    // Select the node's product and linear gradient terms
    always_comb
    begin
        unique case (cnt_reg)
            NODE_V0:
            begin
                mul_a = (MW'(head.l0) <<< 1) - MW'(ONE_L);
                mul_b = MW'(head.l0);
                lin_k = ones - (l0s <<< 2);
                lin_e = ones - (l0s <<< 2);
            end
            NODE_V1:
            begin
                mul_a = (MW'(head.l1) <<< 1) - MW'(ONE_L);
                mul_b = MW'(head.l1);
                lin_k = (l1s <<< 2) - ones;
                lin_e = '0;
            end
            NODE_V2:
            begin
                mul_a = (MW'(head.l2) <<< 1) - MW'(ONE_L);
                mul_b = MW'(head.l2);
                lin_k = '0;
                lin_e = (l2s <<< 2) - ones;
            end
            NODE_E01:
            begin
                mul_a = MW'(head.l0);
                mul_b = MW'(head.l1);
                lin_k = (l0s - l1s) <<< 2;
                lin_e = -(l1s <<< 2);
            end
            NODE_E12:
            begin
                mul_a = MW'(head.l1);
                mul_b = MW'(head.l2);
                lin_k = l2s <<< 2;
                lin_e = l1s <<< 2;
            end
            NODE_E20:
            begin
                mul_a = MW'(head.l2);
                mul_b = MW'(head.l0);
                lin_k = -(l2s <<< 2);
                lin_e = (l0s - l2s) <<< 2;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
                lin_k = '0;
                lin_e = '0;
            end
        endcase
    end

    assign mul_p = (2*MW)'(mul_a) * (2*MW)'(mul_b);

    // Stage A: product and gradient sums
    always_ff @(posedge clk)
    begin
        node_a_reg <= cnt_reg;
        q_a_reg    <= mul_p;
        vadd_a_reg <= coef_mul(phis, cnt_reg);
        gk_a_reg   <= (lin_k <<< FRAC_BITS) + coef_mul(dpks, cnt_reg);
        ge_a_reg   <= (lin_e <<< FRAC_BITS) + coef_mul(dpes, cnt_reg);
    end

    // Scale the product: corners as is, edges by four, bubble has none
    assign qs = SW'(q_a_reg);

    always_comb
    begin
        unique case (node_a_reg)
            NODE_V0, NODE_V1, NODE_V2:    qscaled = qs;
            NODE_E01, NODE_E12, NODE_E20: qscaled = qs <<< 2;
            NODE_BUB:                     qscaled = '0;
            default:                      qscaled = '0;
        endcase
    end

    // Stage B: shape value sum
    always_ff @(posedge clk)
    begin
        node_b_reg <= node_a_reg;
        v_b_reg    <= qscaled + vadd_a_reg;
        gk_b_reg   <= gk_a_reg;
        ge_b_reg   <= ge_a_reg;
    end

    // Stage C: round, saturate and register the result beat
    always_ff @(posedge clk)
    begin
        result_reg.node     <= node_b_reg;
        result_reg.value    <= round_sat(v_b_reg);
        result_reg.grad_ksi <= round_sat(gk_b_reg);
        result_reg.grad_eta <= round_sat(ge_b_reg);
        result_reg.last     <= (node_b_reg == NODE_BUB);
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

// ===== sv/p2_bubble_triangle_shape_eval_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2_bubble_triangle_shape_eval_unit: seven-node triangle shape functions
// A point (ksi, eta) in signed fixed point goes in on item when start is high
// and busy is low. The unit returns seven result beats, nodes 0 to 6 in
// order, each with the shape value and its ksi and eta derivatives, rounded
// half up and saturated to 24 bits; last marks the bubble node.
// Each result beat shows on result for one cycle with result_valid high;
// the receiver cannot stall it and must take it in that cycle.
// The result port carries one node per cycle while the queue holds a point,
// and it bounds the sustained point rate. The intake side runs each point
// through its steps on a single shared multiplier, and a two-entry queue
// lets it take the next point while earlier nodes are still being issued;
// busy is high while that sequencer works through its steps, and stays high
// in its last step for as long as the queue has no room.
// Reset clears the sequencer, the queue and the result strobe; a point in
// flight is dropped.
// ----------------------------------------------------------------------------
module p2_bubble_triangle_shape_eval_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  p2b_pkg::item_t   item,
    output logic             result_valid,
    output p2b_pkg::result_t result
);
    import p2b_pkg::*;

    logic  q_push, q_full, q_pop, q_avail;
    coef_t q_wdata, q_head;

    // Intake and shared-term sequencer
    p2b_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full)
    );

    // Decoupling queue
    p2b_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .head      (q_head)
    );

    // Per-node evaluation
    p2b_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .avail        (q_avail),
        .head         (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

// ===== bench/tb_p2_bubble_triangle_shape_eval_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_p2_bubble_triangle_shape_eval_unit: self-checking bench for the
// seven-node triangle shape unit
// Feeds points through the start/busy command port and predicts the seven
// node beats of each point in 64-bit integer arithmetic. Every beat is
// checked field by field against the oldest prediction. Stimulus is a short
// directed set (corners, midpoints, centroid, outside points, coordinate
// extremes, rounding and saturation cases) followed by random points, most
// inside the triangle or within half the coordinate range, the rest anywhere.
// ----------------------------------------------------------------------------
module tb_p2_bubble_triangle_shape_eval_unit;
    import p2b_pkg::*;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  RANDOM_PTS   = 250;
    localparam int  QUIET_TAIL   = 40;
    localparam int  TAIL_CYCLES  = 24;
    localparam longint ONE       = longint'(1) <<< FRAC_BITS;
    localparam longint OUT_MAX   = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint OUT_MIN   = -(longint'(1) <<< (OUT_W - 1));

    typedef struct {
        item_t pt;
        bit    drain;
    } queued_point_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    result_valid;
    result_t result;

    queued_point_t point_queue[$];
    result_t       node_beats_due[$];
    int            gap_left;
    int            points_taken;
    int            beats_seen;
    int            sat_fields;
    int            errors;
    int            cycles;

    p2_bubble_triangle_shape_eval_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Round half up from 2*FRAC_BITS to FRAC_BITS fraction bits
    function automatic longint round_frac(input longint x);
        return (x + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // Round, then clamp to the 24-bit output range
    function automatic logic signed [OUT_W-1:0] out_sat(input longint x2f);
        longint r;
        r = round_frac(x2f);
        if (r > OUT_MAX)
        begin
            r = OUT_MAX;
            sat_fields++;
        end
        else if (r < OUT_MIN)
        begin
            r = OUT_MIN;
            sat_fields++;
        end
        return r[OUT_W-1:0];
    endfunction

    // Work out the seven node beats of one point and queue them in node order
    function automatic void predict_shape_nodes(input item_t pt);
        longint  l0, l1, l2, phi, dpk, dpe;
        longint  v[7];
        longint  gk[7];
        longint  ge[7];
        result_t r;
        l1  = $signed(pt.ksi);
        l2  = $signed(pt.eta);
        l0  = ONE - l1 - l2;
        phi = round_frac(l0 * (l1 * l2));
        dpk = l2 * (l0 - l1);
        dpe = l1 * (l0 - l2);

        v[NODE_V0]  = (2 * l0 - ONE) * l0 + 3 * phi;
        v[NODE_V1]  = (2 * l1 - ONE) * l1 + 3 * phi;
        v[NODE_V2]  = (2 * l2 - ONE) * l2 + 3 * phi;
        v[NODE_E01] = 4 * l0 * l1 - 12 * phi;
        v[NODE_E12] = 4 * l1 * l2 - 12 * phi;
        v[NODE_E20] = 4 * l2 * l0 - 12 * phi;
        v[NODE_BUB] = 27 * phi;

        gk[NODE_V0]  = -(4 * l0 - ONE) * ONE + 3 * dpk;
        ge[NODE_V0]  = -(4 * l0 - ONE) * ONE + 3 * dpe;
        gk[NODE_V1]  = (4 * l1 - ONE) * ONE + 3 * dpk;
        ge[NODE_V1]  = 3 * dpe;
        gk[NODE_V2]  = 3 * dpk;
        ge[NODE_V2]  = (4 * l2 - ONE) * ONE + 3 * dpe;
        gk[NODE_E01] = 4 * (l0 - l1) * ONE - 12 * dpk;
        ge[NODE_E01] = -4 * l1 * ONE - 12 * dpe;
        gk[NODE_E12] = 4 * l2 * ONE - 12 * dpk;
        ge[NODE_E12] = 4 * l1 * ONE - 12 * dpe;
        gk[NODE_E20] = -4 * l2 * ONE - 12 * dpk;
        ge[NODE_E20] = 4 * (l0 - l2) * ONE - 12 * dpe;
        gk[NODE_BUB] = 27 * dpk;
        ge[NODE_BUB] = 27 * dpe;

        for (int k = NODE_V0; k <= NODE_BUB; k++)
        begin
            r.node     = k[NODE_W-1:0];
            r.value    = out_sat(v[k]);
            r.grad_ksi = out_sat(gk[k]);
            r.grad_eta = out_sat(ge[k]);
            r.last     = (k == NODE_BUB);
            node_beats_due.push_back(r);
        end
    endfunction

    function automatic void add_point(input int k, input int e, input bit drain);
        queued_point_t q;
        q.pt.ksi = k[IN_W-1:0];
        q.pt.eta = e[IN_W-1:0];
        q.drain  = drain;
        point_queue.push_back(q);
    endfunction

    // Signed value in [-span, span]
    function automatic int rand_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Driver: take a beat on start && !busy, then idle or present the next point
    always @(posedge clk or negedge rst_n)
    begin
        bit    took;
        bit    nxt_start;
        item_t nxt_item;
        if (!rst_n)
        begin
            start    <= 1'b0;
            item     <= '0;
            gap_left = 0;
        end
        else
        begin
            took      = start && !busy;
            nxt_start = 1'b0;
            nxt_item  = item;
            if (took)
            begin
                predict_shape_nodes(item);
                points_taken++;
                void'(point_queue.pop_front());
                if (point_queue.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 17);
            end
            if (gap_left > 0)
                gap_left = gap_left - 1;
            else if (point_queue.size() > 0 &&
                     !(point_queue[0].drain && node_beats_due.size() != 0))
            begin
                nxt_start = 1'b1;
                nxt_item  = point_queue[0].pt;
            end
            start <= nxt_start;
            item  <= nxt_item;
        end
    end

    // Monitor: check each node beat against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            beats_seen++;
            if (node_beats_due.size() == 0)
            begin
                $error("unexpected node beat: node %0d", result.node);
                errors++;
            end
            else
            begin
                want = node_beats_due.pop_front();
                if (result.node !== want.node)
                begin
                    $error("node: expected %0d, got %0d", want.node, result.node);
                    errors++;
                end
                if (result.value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", want.value, result.value);
                    errors++;
                end
                if (result.grad_ksi !== want.grad_ksi)
                begin
                    $error("grad_ksi: expected %0d, got %0d", want.grad_ksi,
                           result.grad_ksi);
                    errors++;
                end
                if (result.grad_eta !== want.grad_eta)
                begin
                    $error("grad_eta: expected %0d, got %0d", want.grad_eta,
                           result.grad_eta);
                    errors++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, result.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("p2_bubble_triangle_shape_eval_unit: mismatch");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int mode;
        int k;
        int e;
        int big;
        points_taken = 0;
        beats_seen   = 0;
        sat_fields   = 0;
        errors       = 0;
        big          = 1 << (IN_W - 1);

        // Corners, edge midpoints, centroid
        add_point(0, 0, 1'b0);
        add_point(65536, 0, 1'b0);
        add_point(0, 65536, 1'b0);
        add_point(32768, 0, 1'b0);
        add_point(32768, 32768, 1'b0);
        add_point(0, 32768, 1'b0);
        add_point(21845, 21845, 1'b0);
        // One-LSB points, where rounding half up matters
        add_point(1, 1, 1'b0);
        add_point(-1, -1, 1'b0);
        add_point(1, -1, 1'b0);
        // Outside the triangle
        add_point(-65536, 131072, 1'b0);
        add_point(98304, 98304, 1'b0);
        // Coordinate extremes, driving the outputs into saturation
        add_point(big - 1, big - 1, 1'b0);
        add_point(-big, -big, 1'b0);
        add_point(big - 1, -big, 1'b0);
        add_point(-big, big - 1, 1'b0);
        add_point(big - 1, 0, 1'b0);
        add_point(0, -big, 1'b0);
        add_point(-1, big - 1, 1'b0);

        // Random points; pause now and then until every beat is back
        for (int i = 0; i < RANDOM_PTS; i++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
            begin
                k = $urandom_range(0, 65536);
                e = $urandom_range(0, 65536 - k);
            end
            else if (mode < 8)
            begin
                k = rand_signed(1 << 18);
                e = rand_signed(1 << 18);
            end
            else
            begin
                k = $urandom;
                e = $urandom;
            end
            add_point(k, e, (i == 0) || (i % 60 == 59));
        end

        @(posedge rst_n);
        while (point_queue.size() != 0 || start)
            @(posedge clk);
        while (node_beats_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (node_beats_due.size() != 0)
        begin
            $error("%0d node beats never arrived", node_beats_due.size());
            errors++;
        end

        $display("covered %0d points (corners, midpoints, extremes, random), %0d node beats",
                 points_taken, beats_seen);
        $display("saturated output fields predicted: %0d, errors: %0d", sat_fields, errors);
        if (errors == 0)
            $display("p2_bubble_triangle_shape_eval_unit: match");
        else
            $display("p2_bubble_triangle_shape_eval_unit: mismatch");
        $finish;
    end

endmodule
